// ===== rtl/rpd_pkg.sv =====
// ----------------------------------------------------------------------------
// rpd_pkg
// Types and constants shared by the packet deframer modules.
// ----------------------------------------------------------------------------
package rpd_pkg;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_HASH   = 8'h23;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_COLON  = 8'h3A;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_TX      = 2'd1;
   localparam logic [1:0] KIND_GOOD    = 2'd2;
   localparam logic [1:0] KIND_DISCARD = 2'd3;

   localparam logic [1:0] REASON_CHECKSUM = 2'd0;
   localparam logic [1:0] REASON_RESTART  = 2'd1;
   localparam logic [1:0] REASON_OVERFLOW = 2'd2;

   localparam int CMD_QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_PAYLOAD,
      PH_HIGH,
      PH_LOW
   } phase_type;

   typedef enum logic [2:0] {
      CMD_PAYLOAD,
      CMD_PAYLOAD_OVF,
      CMD_RESTART,
      CMD_ACK,
      CMD_ACK_SEQ,
      CMD_NAK
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type  op;
      logic [7:0]  data;
      logic [7:0]  seq0;
      logic [7:0]  seq1;
   } cmd_type;

endpackage

// ===== rtl/rpd_front.sv =====
// ----------------------------------------------------------------------------
// rpd_front
// Framing state machine: classifies each received byte, keeps the sums and
// counts, and issues one command per byte that produces results.
// ----------------------------------------------------------------------------
module rpd_front
   import rpd_pkg::*;
#(
   parameter int BUFFER_BYTES = 512
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic [7:0] rx_byte,
   output logic       cmd_valid,
   output cmd_type    cmd
);

   localparam int CW = $clog2(BUFFER_BYTES);
   localparam logic [CW-1:0] COUNT_LIMIT = CW'(BUFFER_BYTES - 1);

   phase_type     phase_ff, phase_in;
   logic [7:0]    running_sum_ff, running_sum_in;
   logic [7:0]    sent_sum_ff, sent_sum_in;
   logic [CW-1:0] count_ff, count_in;
   logic          has_seq_ff, has_seq_in;
   logic [7:0]    held_ff [2];

   logic          take;
   logic          is_dollar, is_hash;
   logic [CW-1:0] count_plus;
   logic          overflow;
   logic [3:0]    hex_val;
   logic          hex_ok;
   logic [7:0]    low_sum;
   logic          held_wr;

   assign take       = in_valid && !rx_byte[7];
   assign is_dollar  = rx_byte == CHAR_DOLLAR;
   assign is_hash    = rx_byte == CHAR_HASH;
   assign count_plus = count_ff + CW'(1);
   assign overflow   = count_plus == COUNT_LIMIT;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
         hex_val = 4'(rx_byte - 8'h30);
      end else if (rx_byte >= 8'h61 && rx_byte <= 8'h66) begin
         hex_val = 4'(rx_byte - 8'h57);
      end else if (rx_byte >= 8'h41 && rx_byte <= 8'h46) begin
         hex_val = 4'(rx_byte - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign low_sum = hex_ok ? sent_sum_ff + {4'd0, hex_val} : sent_sum_ff + 8'hFF;

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         case (phase_ff)
            PH_HUNT: begin
               if (is_dollar) phase_in = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               if (is_dollar)     phase_in = PH_PAYLOAD;
               else if (is_hash)  phase_in = PH_HIGH;
               else if (overflow) phase_in = PH_HUNT;
            end
            PH_HIGH: phase_in = PH_LOW;
            PH_LOW:  phase_in = PH_HUNT;
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   // datapath and command
   always_comb begin
      running_sum_in = running_sum_ff;
      sent_sum_in    = sent_sum_ff;
      count_in       = count_ff;
      has_seq_in     = has_seq_ff;
      held_wr        = 1'b0;
      cmd_valid      = 1'b0;
      cmd.op         = CMD_PAYLOAD;
      cmd.data       = rx_byte;
      cmd.seq0       = held_ff[0];
      cmd.seq1       = held_ff[1];
      if (take) begin
         case (phase_ff)
            PH_HUNT: begin
               if (is_dollar) begin
                  running_sum_in = 8'd0;
                  count_in       = '0;
                  has_seq_in     = 1'b0;
               end
            end
            PH_PAYLOAD: begin
               if (is_dollar) begin
                  cmd_valid      = 1'b1;
                  cmd.op         = CMD_RESTART;
                  running_sum_in = 8'd0;
                  count_in       = '0;
                  has_seq_in     = 1'b0;
               end else if (!is_hash) begin
                  held_wr        = count_ff < CW'(2);
                  if (count_ff == CW'(2) && rx_byte == CHAR_COLON) has_seq_in = 1'b1;
                  count_in       = count_plus;
                  running_sum_in = running_sum_ff + rx_byte;
                  cmd_valid      = 1'b1;
                  cmd.op         = overflow ? CMD_PAYLOAD_OVF : CMD_PAYLOAD;
               end
            end
            PH_HIGH: begin
               sent_sum_in = hex_ok ? {hex_val, 4'd0} : 8'hF0;
            end
            PH_LOW: begin
               sent_sum_in = low_sum;
               cmd_valid   = 1'b1;
               if (low_sum == running_sum_ff) begin
                  cmd.op = has_seq_ff ? CMD_ACK_SEQ : CMD_ACK;
               end else begin
                  cmd.op = CMD_NAK;
               end
            end
            default: begin
               cmd_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         running_sum_ff <= 8'd0;
         sent_sum_ff    <= 8'd0;
         count_ff       <= '0;
         has_seq_ff     <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         running_sum_ff <= running_sum_in;
         sent_sum_ff    <= sent_sum_in;
         count_ff       <= count_in;
         has_seq_ff     <= has_seq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (held_wr) held_ff[count_ff[0]] <= rx_byte;
   end

endmodule

// ===== rtl/rpd_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// rpd_cmd_queue
// Short first-in first-out queue of commands between front and back.
// ----------------------------------------------------------------------------
module rpd_cmd_queue
   import rpd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head
);

   localparam int AW = $clog2(CMD_QUEUE_DEPTH);

   cmd_type         slot_ff [CMD_QUEUE_DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [AW:0]     count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = count_ff == (AW+1)'(CMD_QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == AW'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == AW'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      if (do_push && !do_pop)      count_in = count_ff + (AW+1)'(1);
      else if (do_pop && !do_push) count_in = count_ff - (AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

// ===== rtl/rpd_back.sv =====
// ----------------------------------------------------------------------------
// rpd_back
// Expands each command into its result items, one per cycle while out_pop
// takes them, through a single output register.
// ----------------------------------------------------------------------------
module rpd_back
   import rpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_empty,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   input  logic       out_pop,
   output logic       out_empty,
   output logic [1:0] out_kind,
   output logic [7:0] out_data,
   output logic [1:0] out_reason,
   output logic       out_last
);

   logic [1:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] data_ff, data_in;
   logic [1:0] reason_ff, reason_in;
   logic       last_ff, last_in;
   logic       load;

   assign load = !cmd_empty && (!valid_ff || out_pop);

   // result for the current command and step
   always_comb begin
      kind_in   = KIND_DISCARD;
      data_in   = 8'd0;
      reason_in = REASON_CHECKSUM;
      last_in   = 1'b1;
      case (cmd.op)
         CMD_PAYLOAD: begin
            kind_in = KIND_PAYLOAD;
            data_in = cmd.data;
         end
         CMD_PAYLOAD_OVF: begin
            if (step_ff == 2'd0) begin
               kind_in = KIND_PAYLOAD;
               data_in = cmd.data;
               last_in = 1'b0;
            end else begin
               reason_in = REASON_OVERFLOW;
            end
         end
         CMD_RESTART: begin
            reason_in = REASON_RESTART;
         end
         CMD_ACK: begin
            if (step_ff == 2'd0) begin
               kind_in = KIND_TX;
               data_in = CHAR_PLUS;
               last_in = 1'b0;
            end else begin
               kind_in = KIND_GOOD;
            end
         end
         CMD_ACK_SEQ: begin
            case (step_ff)
               2'd0: begin
                  kind_in = KIND_TX;
                  data_in = CHAR_PLUS;
                  last_in = 1'b0;
               end
               2'd1: begin
                  kind_in = KIND_TX;
                  data_in = cmd.seq0;
                  last_in = 1'b0;
               end
               2'd2: begin
                  kind_in = KIND_TX;
                  data_in = cmd.seq1;
                  last_in = 1'b0;
               end
               default: begin
                  kind_in = KIND_GOOD;
               end
            endcase
         end
         CMD_NAK: begin
            if (step_ff == 2'd0) begin
               kind_in = KIND_TX;
               data_in = CHAR_MINUS;
               last_in = 1'b0;
            end
         end
         default: begin
            kind_in = KIND_DISCARD;
         end
      endcase
   end

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff && !out_pop;
      cmd_pop  = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (last_in) begin
            step_in = 2'd0;
            cmd_pop = 1'b1;
         end else begin
            step_in = step_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= kind_in;
         data_ff   <= data_in;
         reason_ff <= reason_in;
         last_ff   <= last_in;
      end
   end

   assign out_empty  = !valid_ff;
   assign out_kind   = kind_ff;
   assign out_data   = data_ff;
   assign out_reason = reason_ff;
   assign out_last   = last_ff;

endmodule

// ===== rtl/rsp_packet_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// rsp_packet_deframer_unit
// Receive-side packet deframer for a remote serial protocol link.
//
// Input queue port: req_rx_byte is taken when req_push is high and req_full
// is low, one byte per cycle. Result queue port: while rsp_empty is low the
// oldest result sits on rsp_kind, rsp_data, rsp_discard_reason and rsp_last;
// rsp_pop takes it. rsp_last marks the final result of one input byte.
// A byte is classified in the cycle it is taken and its command enters a
// four-entry queue; the back end turns each command into one to four
// results at one result per cycle while rsp_pop takes them; a command passes
// through the queue and then the output register. Sustained rate is set by
// the back end: one byte per cycle for payload while results are popped; a
// checksum byte that acks with a sequence id gives four results. A stalled
// receiver fills the command queue and req_full rises; nothing is dropped.
// Reset returns the framer to hunt for a start byte and empties both queues.
// ----------------------------------------------------------------------------
module rsp_packet_deframer_unit
   import rpd_pkg::*;
#(
   parameter int BUFFER_BYTES = 512
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data,
   output logic [1:0] rsp_discard_reason,
   output logic       rsp_last
);

   logic    accept;
   logic    front_valid;
   cmd_type front_cmd;
   logic    q_full, q_empty, q_pop;
   cmd_type q_head;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   rpd_front #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .rx_byte   (req_rx_byte),
      .cmd_valid (front_valid),
      .cmd       (front_cmd)
   );

   rpd_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_valid),
      .push_cmd (front_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   rpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_empty  (q_empty),
      .cmd        (q_head),
      .cmd_pop    (q_pop),
      .out_pop    (rsp_pop),
      .out_empty  (rsp_empty),
      .out_kind   (rsp_kind),
      .out_data   (rsp_data),
      .out_reason (rsp_discard_reason),
      .out_last   (rsp_last)
   );

endmodule

// ===== tb/rsp_packet_deframer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// rsp_packet_deframer_unit_tb
// Self-checking bench for the packet deframer. Serial bytes go in through the
// push/full queue port. An in-bench model of the framer predicts the results
// (payload echo, ack or nak, sequence id echo and discards) except where a
// short table of directed bytes, run first, types them in. Random packets
// follow, most of them well formed and the rest noise, restarts, bad sums
// and bad digits; one of two long packets reaches the payload limit. Both
// sides idle at random; a long receiver hold-off once stalls the input.
// ----------------------------------------------------------------------------
module rsp_packet_deframer_unit_tb;
   import rpd_pkg::*;

   localparam int PAYLOAD_LIMIT = 512;
   localparam int RANDOM_ITEMS  = 170;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 16;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PRINT_LIMIT   = 100;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [1:0] reason;
      logic       last;
   } deframe_result_type;

   typedef struct {
      logic [7:0]         rx;
      int                 typed_n;
      deframe_result_type typed;
   } directed_row_type;

   localparam deframe_result_type NO_RESULT = '0;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_data;
   logic [1:0] rsp_discard_reason;
   logic       rsp_last;

   // framer state as predicted
   phase_type  frame_phase = PH_HUNT;
   logic [7:0] run_sum = 8'h00;
   logic [7:0] sent_sum = 8'h00;
   int         pay_count = 0;
   logic [7:0] held_bytes [2];
   bit         seq_flag = 1'b0;

   deframe_result_type step_res [4];
   int                 step_n;
   bit                 step_affected;
   deframe_result_type pending_results [$];

   directed_row_type directed_rows [23];

   int mismatch_count = 0;
   int cycle_count = 0;
   int counted_items = 0;
   int snd_idle_pct = 14;
   int rsp_idle_pct = 14;
   bit start_hold = 1'b0;

   rsp_packet_deframer_unit #(
      .BUFFER_BYTES(PAYLOAD_LIMIT)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_rx_byte       (req_rx_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_kind          (rsp_kind),
      .rsp_data          (rsp_data),
      .rsp_discard_reason(rsp_discard_reason),
      .rsp_last          (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   function automatic void add_result(input logic [1:0] kind, input logic [7:0] data,
                                      input logic [1:0] reason);
      step_res[step_n] = '{kind, data, reason, 1'b0};
      step_n++;
   endfunction

   function automatic void open_packet();
      frame_phase = PH_PAYLOAD;
      run_sum     = 8'h00;
      pay_count   = 0;
      seq_flag    = 1'b0;
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b1, 4'(c - 8'h30)};
      if (c >= "a" && c <= "f") return {1'b1, 4'(c - 8'h57)};
      if (c >= "A" && c <= "F") return {1'b1, 4'(c - 8'h37)};
      return 5'b0_0000;
   endfunction

   function automatic void deframe_byte(input logic [7:0] c);
      logic [4:0] digit;
      step_n        = 0;
      step_affected = 1'b0;
      if (c[7])
         return;
      digit = hex_decode(c);
      case (frame_phase)
         PH_HUNT: begin
            if (c == CHAR_DOLLAR) begin
               open_packet();
               step_affected = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            step_affected = 1'b1;
            if (c == CHAR_DOLLAR) begin
               add_result(KIND_DISCARD, 8'h00, REASON_RESTART);
               open_packet();
            end else if (c == CHAR_HASH) begin
               frame_phase = PH_HIGH;
            end else begin
               if (pay_count < 2)
                  held_bytes[pay_count] = c;
               if (pay_count == 2 && c == CHAR_COLON)
                  seq_flag = 1'b1;
               pay_count++;
               run_sum = run_sum + c;
               add_result(KIND_PAYLOAD, c, REASON_CHECKSUM);
               if (pay_count >= PAYLOAD_LIMIT - 1) begin
                  add_result(KIND_DISCARD, 8'h00, REASON_OVERFLOW);
                  frame_phase = PH_HUNT;
               end
            end
         end
         PH_HIGH: begin
            step_affected = 1'b1;
            sent_sum      = digit[4] ? {digit[3:0], 4'h0} : 8'hF0;
            frame_phase   = PH_LOW;
         end
         default: begin
            step_affected = 1'b1;
            sent_sum      = digit[4] ? sent_sum + digit[3:0] : sent_sum - 8'h01;
            frame_phase   = PH_HUNT;
            if (sent_sum == run_sum) begin
               add_result(KIND_TX, CHAR_PLUS, REASON_CHECKSUM);
               if (seq_flag) begin
                  add_result(KIND_TX, held_bytes[0], REASON_CHECKSUM);
                  add_result(KIND_TX, held_bytes[1], REASON_CHECKSUM);
               end
               add_result(KIND_GOOD, 8'h00, REASON_CHECKSUM);
            end else begin
               add_result(KIND_TX, CHAR_MINUS, REASON_CHECKSUM);
               add_result(KIND_DISCARD, 8'h00, REASON_CHECKSUM);
            end
         end
      endcase
      if (step_n > 0)
         step_res[step_n - 1].last = 1'b1;
   endfunction

   // typed_n: -1 predicted, 0 or 1 results typed in
   task automatic push_byte(input logic [7:0] b, input int typed_n,
                            input deframe_result_type typed);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      deframe_byte(b);
      if (step_affected)
         counted_items++;
      if (typed_n < 0) begin
         for (int i = 0; i < step_n; i++)
            pending_results.push_back(step_res[i]);
      end else if (typed_n == 1) begin
         pending_results.push_back(typed);
      end
   endtask

   task automatic send_byte(input logic [7:0] b);
      push_byte(b, -1, NO_RESULT);
   endtask

   function automatic logic [7:0] payload_char();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 127));
      while (b == CHAR_DOLLAR || b == CHAR_HASH);
      return b;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 10)
         return 8'h30 + n;
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
   endfunction

   task automatic send_packet();
      int unsigned mode;
      int unsigned len;
      logic [7:0]  b;
      logic [7:0]  sum;
      logic [7:0]  hi;
      logic [7:0]  lo;
      mode = $urandom_range(0, 19);
      if (mode < 2) begin
         repeat ($urandom_range(1, 6))
            send_byte(8'($urandom_range(0, 255)));
         return;
      end
      send_byte(CHAR_DOLLAR);
      sum = 8'h00;
      len = $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
         b = payload_char();
         if (i == 2 && $urandom_range(0, 1))
            b = CHAR_COLON;
         send_byte(b);
         sum = sum + b;
         if ($urandom_range(0, 15) == 0)
            send_byte(8'($urandom_range(128, 255)));
      end
      // open packet left for the next start byte to restart
      if (mode < 4)
         return;
      send_byte(CHAR_HASH);
      if (mode < 6)
         sum = sum ^ 8'($urandom_range(1, 255));
      hi = hex_char(sum[7:4]);
      lo = hex_char(sum[3:0]);
      if (mode == 6)
         hi = 8'($urandom_range(0, 127));
      if (mode == 7)
         lo = 8'($urandom_range(0, 127));
      send_byte(hi);
      send_byte(lo);
   endtask

   task automatic send_long_packet(input int len);
      logic [7:0] b;
      logic [7:0] sum;
      sum = 8'h00;
      send_byte(CHAR_DOLLAR);
      for (int i = 0; i < len; i++) begin
         b = (i == 2) ? CHAR_COLON : payload_char();
         send_byte(b);
         sum = sum + b;
      end
      send_byte(CHAR_HASH);
      send_byte(hex_char(sum[7:4]));
      send_byte(hex_char(sum[3:0]));
   endtask

   task automatic check_result(input deframe_result_type got);
      deframe_result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch($sformatf("unexpected result kind %0d data %02h reason %0d last %0d",
                                   got.kind, got.data, got.reason, got.last));
         return;
      end
      want = pending_results.pop_front();
      if (got.kind != want.kind)
         report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
      if (got.data != want.data)
         report_mismatch($sformatf("data got %02h want %02h", got.data, want.data));
      if (got.reason != want.reason)
         report_mismatch($sformatf("discard reason got %0d want %0d",
                                   got.reason, want.reason));
      if (got.last != want.last)
         report_mismatch($sformatf("last got %0d want %0d", got.last, want.last));
   endtask

   // result side
   initial begin
      int hold_left;
      hold_left = 0;
      while (reset)
         @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty)
            check_result('{rsp_kind, rsp_data, rsp_discard_reason, rsp_last});
         if (start_hold) begin
            start_hold = 1'b0;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // item side
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      directed_rows = '{
         '{"A",         0, NO_RESULT},
         '{8'hFF,       0, NO_RESULT},
         '{8'h80,       0, NO_RESULT},
         '{CHAR_DOLLAR, 0, NO_RESULT},
         '{8'h00,       1, '{KIND_PAYLOAD, 8'h00, REASON_CHECKSUM, 1'b1}},
         '{8'h7F,       1, '{KIND_PAYLOAD, 8'h7F, REASON_CHECKSUM, 1'b1}},
         '{CHAR_COLON,  1, '{KIND_PAYLOAD, CHAR_COLON, REASON_CHECKSUM, 1'b1}},
         '{8'hC5,       0, NO_RESULT},
         '{CHAR_HASH,   0, NO_RESULT},
         '{"b",        -1, NO_RESULT},
         '{"9",        -1, NO_RESULT},
         '{CHAR_DOLLAR, 0, NO_RESULT},
         '{"x",         1, '{KIND_PAYLOAD, "x", REASON_CHECKSUM, 1'b1}},
         '{CHAR_DOLLAR, 1, '{KIND_DISCARD, 8'h00, REASON_RESTART, 1'b1}},
         '{"q",         1, '{KIND_PAYLOAD, "q", REASON_CHECKSUM, 1'b1}},
         '{CHAR_HASH,   0, NO_RESULT},
         '{CHAR_HASH,   0, NO_RESULT},
         '{CHAR_DOLLAR,-1, NO_RESULT},
         '{CHAR_DOLLAR, 0, NO_RESULT},
         '{"J",         1, '{KIND_PAYLOAD, "J", REASON_CHECKSUM, 1'b1}},
         '{CHAR_HASH,   0, NO_RESULT},
         '{"4",         0, NO_RESULT},
         '{"A",        -1, NO_RESULT}
      };
      repeat (12)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         push_byte(directed_rows[i].rx, directed_rows[i].typed_n, directed_rows[i].typed);

      counted_items = 0;
      while (counted_items < RANDOM_ITEMS) begin
         if (!hold_done && counted_items > 60) begin
            start_hold = 1'b1;
            hold_done  = 1'b1;
         end
         send_packet();
      end

      // no idling on either side while the payload limit is reached
      snd_idle_pct = 0;
      rsp_idle_pct = 0;
      send_long_packet(PAYLOAD_LIMIT - 1);
      send_long_packet(PAYLOAD_LIMIT - 2);
      snd_idle_pct = 14;
      rsp_idle_pct = 14;
      repeat (20)
         send_packet();
      req_push <= 1'b0;

      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES)
         @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
